>>> rtl/core/ifd_pkg.sv
// Shared types and constants for the interleaved frame deframer.
`default_nettype none

package ifd_pkg;

    localparam logic [7:0] FRAME_MARK = 8'h24;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_SET   = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_MARK  = 3'd1,
        PH_CHAN  = 3'd2,
        PH_LENHI = 3'd3,
        PH_BODY  = 3'd4
    } phase_t;

    localparam logic OUT_TEXT    = 1'b0;
    localparam logic OUT_PAYLOAD = 1'b1;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] connection;
        logic [7:0] data_byte;
        logic [7:0] reg_channel;
    } in_item_t;

    typedef struct packed {
        logic        out_kind;
        logic [3:0]  out_connection;
        logic [7:0]  out_channel;
        logic [7:0]  out_byte;
        logic [15:0] frame_length;
        logic        first_byte;
        logic        last_byte;
        logic        empty_frame;
    } out_item_t;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  channel;
        logic [15:0] length;
        logic [15:0] remaining;
    } ctx_t;

    typedef struct packed {
        ctx_t       ctx_next;
        logic       ctx_we;
        logic       reg_we;
        logic       reg_bit;
        logic [7:0] reg_ch;
        logic       need_reg;
        logic [7:0] look_ch;
        logic       res_valid;
        out_item_t  result;
    } step_t;

endpackage

`default_nettype wire

>>> rtl/core/ifd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ifd_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output      logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/core/ifd_step.sv
// Per-request parse step: next connection context and candidate result.
`default_nettype none

module ifd_step
    import ifd_pkg::*;
(
    input  wire in_item_t item,
    input  wire ctx_t     ctx,
    output      step_t    step
);

    logic [15:0] len_full;
    logic [15:0] rem_dec;
    logic        first_flag;
    logic        last_flag;

    assign len_full   = {ctx.length[15:8], item.data_byte};
    assign rem_dec    = ctx.remaining - 16'd1;
    assign first_flag = (ctx.remaining == ctx.length);
    assign last_flag  = (rem_dec == 16'd0);

    always_comb
    begin
        step           = '0;
        step.ctx_next  = ctx;
        step.reg_ch    = item.reg_channel;
        step.look_ch   = ctx.channel;
        step.result.out_connection = item.connection;
        unique case (kind_t'(item.kind))
            KIND_SET:
            begin
                step.reg_we  = 1'b1;
                step.reg_bit = 1'b1;
            end
            KIND_CLEAR:
            begin
                step.reg_we  = 1'b1;
                step.reg_bit = 1'b0;
            end
            KIND_NONE:
            begin
                step.ctx_we = 1'b0;
            end
            KIND_BYTE:
            begin
                unique case (ctx.phase)
                    PH_IDLE:
                    begin
                        if (item.data_byte == FRAME_MARK)
                        begin
                            step.ctx_next.phase = PH_MARK;
                            step.ctx_we         = 1'b1;
                        end
                        else
                        begin
                            step.res_valid          = 1'b1;
                            step.result.out_kind    = OUT_TEXT;
                            step.result.out_byte    = item.data_byte;
                            step.result.last_byte   = 1'b1;
                        end
                    end
                    PH_MARK:
                    begin
                        step.ctx_next.channel = item.data_byte;
                        step.ctx_next.phase   = PH_CHAN;
                        step.ctx_we           = 1'b1;
                    end
                    PH_CHAN:
                    begin
                        step.ctx_next.length = {item.data_byte, 8'd0};
                        step.ctx_next.phase  = PH_LENHI;
                        step.ctx_we          = 1'b1;
                    end
                    PH_LENHI:
                    begin
                        step.ctx_next.length    = len_full;
                        step.ctx_next.remaining = len_full;
                        step.ctx_we             = 1'b1;
                        if (len_full != 16'd0)
                        begin
                            step.ctx_next.phase = PH_BODY;
                        end
                        else
                        begin
                            step.ctx_next.phase      = PH_IDLE;
                            step.res_valid           = 1'b1;
                            step.need_reg            = 1'b1;
                            step.result.out_kind     = OUT_PAYLOAD;
                            step.result.out_channel  = ctx.channel;
                            step.result.first_byte   = 1'b1;
                            step.result.last_byte    = 1'b1;
                            step.result.empty_frame  = 1'b1;
                        end
                    end
                    PH_BODY:
                    begin
                        step.ctx_next.remaining = rem_dec;
                        step.ctx_we             = 1'b1;
                        if (last_flag)
                        begin
                            step.ctx_next.phase = PH_IDLE;
                        end
                        step.res_valid           = 1'b1;
                        step.need_reg            = 1'b1;
                        step.result.out_kind     = OUT_PAYLOAD;
                        step.result.out_channel  = ctx.channel;
                        step.result.out_byte     = item.data_byte;
                        step.result.frame_length = ctx.length;
                        step.result.first_byte   = first_flag;
                        step.result.last_byte    = last_flag;
                    end
                    default:
                    begin
                        step.ctx_next.phase = PH_IDLE;
                        step.ctx_we         = 1'b1;
                    end
                endcase
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/interleaved_frame_deframer.sv
// Interleaved frame deframer: per-connection parse contexts and channel registration.
// Stages: stage 1 (context read), stage 2 (registration lookup), output register.
// Throughput: one request per cycle, set by the context RAM read-modify-write loop;
// back-to-back requests on one connection take the forwarded context; item_stall halts intake.
// Reset: parse contexts read as idle through per-connection valid flops; the
// registration RAM (CONNECTIONS*256 entries) is then cleared with item_stall high.
`default_nettype none

module interleaved_frame_deframer
    import ifd_pkg::*;
#(
    parameter int CONNECTIONS = 16
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    output      logic      item_stall,
    input  wire in_item_t  item,
    output      logic      result_valid,
    input  wire logic      result_stall,
    output      out_item_t result
);

    localparam int CONN_W    = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
    localparam int CTX_W     = $bits(ctx_t);
    localparam int REG_DEPTH = CONNECTIONS * 256;
    localparam int REG_AW    = $clog2(REG_DEPTH);

    logic              en;
    logic              accept;
    logic              s1_ok;
    logic [CONN_W-1:0] s1_idx;
    ctx_t              ctx_cur;
    step_t             step;
    logic [CTX_W-1:0]  ctx_rdata;
    logic              ctx_we;
    logic              reg_wr_en;
    logic [REG_AW-1:0] reg_wr_addr;
    logic [0:0]        reg_wr_data;
    logic              reg_rd_en;
    logic [REG_AW-1:0] reg_rd_addr;
    logic [0:0]        reg_rdata;

    logic              clear_active_reg;
    logic [REG_AW-1:0] clear_cnt_reg;
    logic [CONNECTIONS-1:0] ctx_valid_reg;
    logic              s1_valid_reg;
    in_item_t          s1_item_reg;
    logic              fwd_hit_reg;
    ctx_t              fwd_ctx_reg;
    logic              s2_valid_reg;
    logic              s2_need_reg;
    out_item_t         s2_result_reg;
    logic              result_valid_reg;
    out_item_t         result_reg;

    assign en         = !result_valid_reg || !result_stall;
    assign item_stall = clear_active_reg || !en;
    assign accept     = item_valid && !item_stall;

    assign s1_idx  = CONN_W'(s1_item_reg.connection);
    assign s1_ok   = s1_valid_reg && (32'(s1_item_reg.connection) < 32'(CONNECTIONS));
    assign ctx_cur = fwd_hit_reg ? fwd_ctx_reg
                   : (ctx_valid_reg[s1_idx] ? ctx_t'(ctx_rdata) : '0);
    assign ctx_we  = en && s1_ok && step.ctx_we;

    ifd_step u_step (
        .item (s1_item_reg),
        .ctx  (ctx_cur),
        .step (step)
    );

    ifd_ram #(
        .WIDTH (CTX_W),
        .DEPTH (CONNECTIONS)
    ) u_ctx_ram (
        .clk     (clk),
        .wr_en   (ctx_we),
        .wr_addr (s1_idx),
        .wr_data (step.ctx_next),
        .rd_en   (accept),
        .rd_addr (CONN_W'(item.connection)),
        .rd_data (ctx_rdata)
    );

    assign reg_wr_en   = clear_active_reg || (en && s1_ok && step.reg_we);
    assign reg_wr_addr = clear_active_reg ? clear_cnt_reg : REG_AW'({s1_idx, step.reg_ch});
    assign reg_wr_data = clear_active_reg ? 1'b0 : step.reg_bit;
    assign reg_rd_en   = en && s1_ok && step.need_reg;
    assign reg_rd_addr = REG_AW'({s1_idx, step.look_ch});

    ifd_ram #(
        .WIDTH (1),
        .DEPTH (REG_DEPTH)
    ) u_reg_ram (
        .clk     (clk),
        .wr_en   (reg_wr_en),
        .wr_addr (reg_wr_addr),
        .wr_data (reg_wr_data),
        .rd_en   (reg_rd_en),
        .rd_addr (reg_rd_addr),
        .rd_data (reg_rdata)
    );

    // sweep the registration store after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clear_cnt_reg    <= '0;
        end
        else if (clear_active_reg)
        begin
            if (clear_cnt_reg == REG_AW'(REG_DEPTH - 1))
            begin
                clear_active_reg <= 1'b0;
            end
            clear_cnt_reg <= clear_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_valid_reg    <= '0;
            s1_valid_reg     <= 1'b0;
            fwd_hit_reg      <= 1'b0;
            s2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            if (ctx_we)
            begin
                ctx_valid_reg[s1_idx] <= 1'b1;
            end
            s1_valid_reg     <= accept;
            fwd_hit_reg      <= accept && ctx_we
                                && (item.connection == s1_item_reg.connection);
            s2_valid_reg     <= s1_ok && step.res_valid;
            result_valid_reg <= s2_valid_reg && (!s2_need_reg || reg_rdata[0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (accept)
            begin
                s1_item_reg <= item;
            end
            fwd_ctx_reg   <= step.ctx_next;
            s2_need_reg   <= step.need_reg;
            s2_result_reg <= step.result;
            result_reg    <= s2_result_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clear_active_reg |-> item_stall)
        else $error("request accepted during registration clear");

    a_fwd_has_stage: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_hit_reg |-> s1_valid_reg)
        else $error("context forward without a request in stage 1");

    a_reg_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(reg_rd_en && clear_active_reg))
        else $error("registration lookup during clear");

    a_result_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.out_kind == OUT_PAYLOAD || result.last_byte))
        else $error("text result without last_byte");

endmodule

`default_nettype wire
